FILE: src/clfp_pkg.sv
// Shared types and constants for the canonical line unit.
package clfp_pkg;

   localparam int COORD_BITS_DEFAULT = 24;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_GCD,
      ST_GFIN,
      ST_DIV,
      ST_SIGN,
      ST_MUL_A,
      ST_MUL_B,
      ST_SUM,
      ST_DONE
   } clfp_state_type;

   typedef struct packed {
      logic load;
      logic diff;
      logic gcd_step;
      logic gcd_fin;
      logic div_step;
      logic sign;
      logic mul_a;
      logic mul_b;
      logic sum;
   } clfp_cmd_type;

   typedef struct packed {
      logic gcd_zero;
      logic div_last;
      logic degen;
   } clfp_sts_type;

endpackage

FILE: src/clfp_ctrl.sv
// Sequencer that steps the datapath through one line computation.
module clfp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  clfp_pkg::clfp_sts_type sts,
   output clfp_pkg::clfp_cmd_type cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   clfp_pkg::clfp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clfp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clfp_pkg::ST_IDLE: begin
            if (start) state_in = clfp_pkg::ST_DIFF;
         end
         clfp_pkg::ST_DIFF:  state_in = clfp_pkg::ST_GCD;
         clfp_pkg::ST_GCD: begin
            if (sts.gcd_zero) state_in = clfp_pkg::ST_GFIN;
         end
         clfp_pkg::ST_GFIN: begin
            // Coincident points have no divisor, so the division is skipped.
            state_in = sts.degen ? clfp_pkg::ST_SIGN : clfp_pkg::ST_DIV;
         end
         clfp_pkg::ST_DIV: begin
            if (sts.div_last) state_in = clfp_pkg::ST_SIGN;
         end
         clfp_pkg::ST_SIGN:  state_in = clfp_pkg::ST_MUL_A;
         clfp_pkg::ST_MUL_A: state_in = clfp_pkg::ST_MUL_B;
         clfp_pkg::ST_MUL_B: state_in = clfp_pkg::ST_SUM;
         clfp_pkg::ST_SUM:   state_in = clfp_pkg::ST_DONE;
         clfp_pkg::ST_DONE:  state_in = clfp_pkg::ST_IDLE;
         default:            state_in = clfp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         clfp_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         clfp_pkg::ST_DIFF:  cmd.diff     = 1'b1;
         clfp_pkg::ST_GCD:   cmd.gcd_step = !sts.gcd_zero;
         clfp_pkg::ST_GFIN:  cmd.gcd_fin  = 1'b1;
         clfp_pkg::ST_DIV:   cmd.div_step = 1'b1;
         clfp_pkg::ST_SIGN:  cmd.sign     = 1'b1;
         clfp_pkg::ST_MUL_A: cmd.mul_a    = 1'b1;
         clfp_pkg::ST_MUL_B: cmd.mul_b    = 1'b1;
         clfp_pkg::ST_SUM:   cmd.sum      = 1'b1;
         clfp_pkg::ST_DONE:  rsp_valid    = 1'b1;
         default:            busy         = 1'b1;
      endcase
   end

endmodule

FILE: src/clfp_datapath.sv
// Datapath: differences, binary gcd, two-lane divider, sign fix and constant term.
module clfp_datapath #(
   parameter int COORD_BITS = clfp_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  clfp_pkg::clfp_cmd_type        cmd,
   output clfp_pkg::clfp_sts_type        sts,
   input  logic signed [COORD_BITS-1:0]  req_first_x,
   input  logic signed [COORD_BITS-1:0]  req_first_y,
   input  logic signed [COORD_BITS-1:0]  req_second_x,
   input  logic signed [COORD_BITS-1:0]  req_second_y,
   output logic signed [COORD_BITS:0]    rsp_coef_a,
   output logic signed [COORD_BITS:0]    rsp_coef_b,
   output logic signed [2*COORD_BITS+1:0] rsp_coef_c,
   output logic                         rsp_degenerate
);

   localparam int DW    = COORD_BITS + 1;
   localparam int CW    = 2 * COORD_BITS + 2;
   localparam int PW    = 2 * COORD_BITS + 1;
   localparam int CNT_W = $clog2(DW);

   logic signed [COORD_BITS-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [DW-1:0] a_ff, b_ff;
   logic [DW-1:0] u_ff, v_ff, g_ff;
   logic [CNT_W-1:0] k_ff, cnt_ff;
   logic [DW-1:0] qa_ff, qb_ff, ra_ff, rb_ff;
   logic signed [DW-1:0] na_ff, nb_ff;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic signed [DW-1:0] ca_ff, cb_ff;
   logic signed [CW-1:0] cc_ff;
   logic degen_ff;

   logic signed [DW-1:0] a_in, b_in;
   logic [DW-1:0] ma_in, mb_in;
   logic [DW:0] ta, tb;
   logic ge_a, ge_b;
   logic [DW:0] da, db;
   logic signed [DW-1:0] sa, sb;
   logic flip;
   logic signed [DW-1:0] mul_c;
   logic signed [COORD_BITS-1:0] mul_x;
   logic signed [PW-1:0] prod;
   logic [DW-1:0] u_sub_v, v_sub_u;

   assign a_in  = DW'(y2_ff) - DW'(y1_ff);
   assign b_in  = DW'(x1_ff) - DW'(x2_ff);
   assign ma_in = a_in[DW-1] ? DW'(-a_in) : DW'(a_in);
   assign mb_in = b_in[DW-1] ? DW'(-b_in) : DW'(b_in);

   assign u_sub_v = u_ff - v_ff;
   assign v_sub_u = v_ff - u_ff;

   // Restoring division, one quotient bit per lane each cycle.
   assign ta   = {ra_ff, qa_ff[DW-1]};
   assign tb   = {rb_ff, qb_ff[DW-1]};
   assign da   = ta - {1'b0, g_ff};
   assign db   = tb - {1'b0, g_ff};
   assign ge_a = ta >= {1'b0, g_ff};
   assign ge_b = tb >= {1'b0, g_ff};

   assign sa   = a_ff[DW-1] ? -$signed(qa_ff) : $signed(qa_ff);
   assign sb   = b_ff[DW-1] ? -$signed(qb_ff) : $signed(qb_ff);
   assign flip = a_ff[DW-1] || ((a_ff == '0) && b_ff[DW-1]);

   // One multiplier, shared between the two products of the constant term.
   assign mul_c = cmd.mul_a ? na_ff : nb_ff;
   assign mul_x = cmd.mul_a ? x1_ff : y1_ff;
   assign prod  = mul_c * mul_x;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x1_ff <= req_first_x;
         y1_ff <= req_first_y;
         x2_ff <= req_second_x;
         y2_ff <= req_second_y;
      end
      if (cmd.diff) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         u_ff   <= ma_in;
         v_ff   <= mb_in;
         qa_ff  <= ma_in;
         qb_ff  <= mb_in;
         ra_ff  <= '0;
         rb_ff  <= '0;
         k_ff   <= '0;
         cnt_ff <= '0;
      end
      if (cmd.gcd_step) begin
         priority if (!u_ff[0] && !v_ff[0]) begin
            u_ff <= u_ff >> 1;
            v_ff <= v_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!u_ff[0]) begin
            u_ff <= u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_ff <= v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_ff <= u_sub_v >> 1;
         end else begin
            v_ff <= v_sub_u >> 1;
         end
      end
      if (cmd.gcd_fin) begin
         g_ff <= (u_ff | v_ff) << k_ff;
      end
      if (cmd.div_step) begin
         ra_ff  <= ge_a ? da[DW-1:0] : ta[DW-1:0];
         rb_ff  <= ge_b ? db[DW-1:0] : tb[DW-1:0];
         qa_ff  <= {qa_ff[DW-2:0], ge_a};
         qb_ff  <= {qb_ff[DW-2:0], ge_b};
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.sign) begin
         na_ff    <= flip ? -sa : sa;
         nb_ff    <= flip ? -sb : sb;
         degen_ff <= (a_ff == '0) && (b_ff == '0);
      end
      if (cmd.mul_a) begin
         p1_ff <= prod;
      end
      if (cmd.mul_b) begin
         p2_ff <= prod;
      end
      if (cmd.sum) begin
         ca_ff <= na_ff;
         cb_ff <= nb_ff;
         cc_ff <= -(CW'(p1_ff) + CW'(p2_ff));
      end
   end

   assign sts.gcd_zero = (u_ff == '0) || (v_ff == '0);
   assign sts.div_last = cnt_ff == CNT_W'(DW - 1);
   assign sts.degen    = (a_ff == '0) && (b_ff == '0);

   assign rsp_coef_a     = ca_ff;
   assign rsp_coef_b     = cb_ff;
   assign rsp_coef_c     = cc_ff;
   assign rsp_degenerate = degen_ff;

endmodule

FILE: src/canonical_line_from_two_points_unit.sv
// Top level: canonical integer line a*x + b*y + c = 0 through two points.
// The time to the result strobe varies with the binary gcd loop and the divider; coincident
// points skip the divider. busy stays high through the strobe, so the unit takes no new pair
// of points before it has finished the last. The receiver cannot stall it. Reset returns the
// sequencer to idle.
module canonical_line_from_two_points_unit #(
   parameter int COORD_BITS = clfp_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_BITS-1:0]   req_first_x,
   input  logic signed [COORD_BITS-1:0]   req_first_y,
   input  logic signed [COORD_BITS-1:0]   req_second_x,
   input  logic signed [COORD_BITS-1:0]   req_second_y,
   output logic                          rsp_valid,
   output logic signed [COORD_BITS:0]     rsp_coef_a,
   output logic signed [COORD_BITS:0]     rsp_coef_b,
   output logic signed [2*COORD_BITS+1:0] rsp_coef_c,
   output logic                          rsp_degenerate
);

   clfp_pkg::clfp_cmd_type cmd;
   clfp_pkg::clfp_sts_type sts;

   clfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   clfp_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .sts            (sts),
      .req_first_x    (req_first_x),
      .req_first_y    (req_first_y),
      .req_second_x   (req_second_x),
      .req_second_y   (req_second_y),
      .rsp_coef_a     (rsp_coef_a),
      .rsp_coef_b     (rsp_coef_b),
      .rsp_coef_c     (rsp_coef_c),
      .rsp_degenerate (rsp_degenerate)
   );

   // An accepted transfer keeps the unit busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("unit not busy after accepting a transfer");

   // The result strobe lasts exactly one cycle.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // The x coefficient is never negative.
   a_coef_a_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_coef_a[COORD_BITS])
      else $error("negative x coefficient");

   // A horizontal line (zero x coefficient) has a positive y coefficient unless degenerate.
   a_coef_b_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_coef_a == '0) && !rsp_degenerate) |->
         (!rsp_coef_b[COORD_BITS] && (rsp_coef_b != '0)))
      else $error("y coefficient not positive when x coefficient is zero");

   // Coincident points give an all-zero line.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         ((rsp_coef_a == '0) && (rsp_coef_b == '0) && (rsp_coef_c == '0)))
      else $error("degenerate result with nonzero coefficients");

endmodule
